@@ src/cci_pkg.sv @@
// ----------------------------------------------------------------------------
// cci_pkg
// Shared types and constants for the commodity channel index stream block.
// ----------------------------------------------------------------------------
package cci_pkg;

    localparam int PRICE_W    = 32;
    localparam int X_W        = 34;   // high + low + close
    localparam int PERIOD_W   = 11;
    localparam int OUT_W      = 40;
    localparam int FRAC_SHIFT = 16;   // Q24.16 signed output scaling
    localparam int SCALE_W    = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 11'd14;
    // 1 / 0.015 = 200 / 3; the 3 goes into the divisor
    localparam logic [SCALE_W-1:0]  SCALE_K    = 8'd200;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // one price bar
    typedef struct packed {
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
    } t_in;

    // one index result
    typedef struct packed {
        logic signed [OUT_W-1:0] index_value;
        logic                    ready_res;
    } t_out;

    // divider control and status
    typedef struct packed {
        logic start;
        logic neg;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_WARM = 9'b000000010,
        ST_PREP = 9'b000000100,
        ST_WALK = 9'b000001000,
        ST_MUL1 = 9'b000010000,
        ST_MUL2 = 9'b000100000,
        ST_MUL3 = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_FIN  = 9'b100000000
    } t_state;

endpackage

@@ src/commodity_channel_index_stream.sv @@
// ----------------------------------------------------------------------------
// commodity_channel_index_stream
// Streaming commodity channel index over a window of price bars.
// ----------------------------------------------------------------------------
// Each bar takes one pass of a sequencer, and one bar is in work at a time.
// During warm-up (the first period-1 bars after reset or a period write) a bar
// goes through acceptance, one window write and one output load. The result
// is marked not ready. After that a bar goes through these steps:
//   - acceptance of the bar, then forming the sum;
//   - a read of the window, one entry per cycle, summing the absolute
//     deviations;
//   - three multiply states;
//   - the bit-serial divider (80 quotient bits, between its start and done
//     strobes);
//   - a load of the output.
// A bar with zero deviation or zero numerator skips the divider. While the
// output register holds a stalled result, the sequencer waits in its last
// state. The output register lets the next bar be taken while a result still
// waits. A period write restarts warm-up.
module commodity_channel_index_stream
    import cci_pkg::*;
#(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out                o_out_data
);

    localparam int CW   = $clog2(WINDOW_MAX);       // slot index and count
    localparam int NW   = $clog2(WINDOW_MAX + 1);   // effective period
    localparam int SW   = X_W + CW;                 // window sum
    localparam int PW   = X_W + NW;                 // n * x
    localparam int DW   = PW + NW;                  // deviation sum
    localparam int DENW = DW + 2;                   // 3 * deviation
    localparam int P1W  = PW + NW;                  // mag * n
    localparam int NUMW = P1W + SCALE_W;            // mag * n * 200

    // state
    t_state              r_state;
    logic [PERIOD_W-1:0] r_period;
    logic [SW-1:0]       r_sum;
    logic [CW-1:0]       r_items;
    logic [CW-1:0]       r_wslot;

    // per-bar work registers
    logic [X_W-1:0]      r_x;
    logic [CW-1:0]       r_slot;
    logic [SW-1:0]       r_s;
    logic [PW-1:0]       r_nx;
    logic [CW-1:0]       r_rd_idx;
    logic                r_v1;
    logic [CW-1:0]       r_i1;
    logic [X_W-1:0]      r_rd_data;
    logic                r_v2;
    logic [PW-1:0]       r_prod;
    logic [X_W-1:0]      r_old;
    logic [DW-1:0]       r_dev;
    logic [PW-1:0]       r_mag;
    logic                r_neg;
    logic                r_zero;
    logic [P1W-1:0]      r_p1;
    logic [DENW-1:0]     r_den;
    logic [NUMW-1:0]     r_num;
    t_out                r_res;
    logic                r_out_valid;
    t_out                r_out;

    logic [X_W-1:0]      mem [WINDOW_MAX-1];

    logic [NW-1:0]       w_n;
    logic [CW-1:0]       w_slots;
    logic [CW-1:0]       w_cur_slot;
    logic [CW-1:0]       w_next_slot;
    logic                w_accept;
    logic                w_issue;
    logic                w_mem_we;
    logic [PW-1:0]       w_s_ext;
    logic [PW-1:0]       w_mag;
    logic                w_out_load;
    t_div_ctl            w_div_ctl;
    t_div_sts            w_div_sts;
    logic signed [OUT_W-1:0] w_quot;

    // effective period, clamped
    always_comb begin
        if (r_period < PERIOD_W'(2)) begin
            w_n = NW'(2);
        end else if (r_period > WINDOW_MAX) begin
            w_n = NW'(WINDOW_MAX);
        end else begin
            w_n = NW'(r_period);
        end
        w_slots = CW'(w_n - NW'(1));
    end

    // slot bookkeeping
    always_comb begin
        w_cur_slot  = (r_wslot >= w_slots) ? '0 : r_wslot;
        w_next_slot = (r_slot + CW'(1) >= w_slots) ? '0 : r_slot + CW'(1);
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_issue    = (r_state == ST_WALK) && (r_rd_idx < w_slots);
    assign w_mem_we   = (r_state == ST_WARM) || (r_state == ST_MUL1);
    assign w_s_ext    = PW'(r_s);
    assign w_mag      = (r_nx >= w_s_ext) ? r_nx - w_s_ext : w_s_ext - r_nx;
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    // window memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_slot] <= r_x;
        end
        r_rd_data <= mem[r_rd_idx];
    end

    // sequencer and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_period <= PERIOD_RST;
            r_sum    <= '0;
            r_items  <= '0;
            r_wslot  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
                r_sum    <= '0;
                r_items  <= '0;
                r_wslot  <= '0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= (r_items < w_slots) ? ST_WARM : ST_PREP;
                    end
                end
                ST_WARM: begin
                    r_sum   <= r_sum + SW'(r_x);
                    r_items <= r_items + CW'(1);
                    r_wslot <= w_next_slot;
                    r_state <= ST_FIN;
                end
                ST_PREP: begin
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (!w_issue && !r_v1 && !r_v2) begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_sum   <= r_s - SW'(r_old);
                    r_wslot <= w_next_slot;
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_state <= ST_MUL3;
                end
                ST_MUL3: begin
                    r_state <= r_zero ? ST_FIN : ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_sts.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // read pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    // per-bar datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= X_W'(i_in_data.high_price) + X_W'(i_in_data.low_price)
                    + X_W'(i_in_data.close_price);
            r_slot <= w_cur_slot;
        end
        if (r_state == ST_WARM) begin
            r_res.index_value <= '0;
            r_res.ready_res   <= 1'b0;
        end
        if (r_state == ST_PREP) begin
            r_s      <= r_sum + SW'(r_x);
            r_nx     <= PW'(r_x) * PW'(w_n);
            r_rd_idx <= '0;
            r_dev    <= '0;
        end
        // walk: issue, multiply, accumulate
        if (w_issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        r_i1 <= r_rd_idx;
        if (r_v1) begin
            r_prod <= PW'(r_rd_data) * PW'(w_n);
            if (r_i1 == r_slot) begin
                r_old <= r_rd_data;
            end
        end
        if (r_v2) begin
            r_dev <= r_dev + DW'((r_prod >= w_s_ext) ? r_prod - w_s_ext
                                                     : w_s_ext - r_prod);
        end
        // current bar term, sign and magnitude
        if (r_state == ST_MUL1) begin
            r_mag <= w_mag;
            r_neg <= (r_nx < w_s_ext);
            r_dev <= r_dev + DW'(w_mag);
        end
        if (r_state == ST_MUL2) begin
            r_p1   <= P1W'(r_mag) * P1W'(w_n);
            r_den  <= DENW'(r_dev) + (DENW'(r_dev) << 1);
            r_zero <= (r_mag == '0) || (r_dev == '0);
        end
        if (r_state == ST_MUL3) begin
            r_num <= NUMW'(r_p1) * NUMW'(SCALE_K);
            if (r_zero) begin
                r_res.index_value <= '0;
                r_res.ready_res   <= 1'b1;
            end
        end
        if ((r_state == ST_DIV) && w_div_sts.done) begin
            r_res.index_value <= w_quot;
            r_res.ready_res   <= 1'b1;
        end
    end

    // divider, started on the first divide cycle once the numerator is registered
    assign w_div_ctl.start = (r_state == ST_DIV) && !w_div_sts.busy && !w_div_sts.done;
    assign w_div_ctl.neg   = r_neg;

    cci_div #(
        .NUM_W (NUMW),
        .DEN_W (DENW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_sts   (w_div_sts),
        .o_quot  (w_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // no window write while the window is being read
    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> !w_mem_we)
        else $error("window write during walk");

    // a warm-up result carries a zero index
    a_warm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.ready_res) |-> (r_out.index_value == '0))
        else $error("nonzero index during warm-up");

    // the stored count never passes the window size
    a_items_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_items <= w_slots))
        else $error("item count beyond window");

    // divider completes only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");
`endif

endmodule

@@ src/cci_div.sv @@
// ----------------------------------------------------------------------------
// cci_div
// Restoring divider, one quotient bit per cycle. Divides (num << 16) by den
// and returns the signed, saturated 40-bit quotient.
// ----------------------------------------------------------------------------
module cci_div
    import cci_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 58
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_ctl                i_ctl,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [DEN_W-1:0]        i_den,
    output t_div_sts                o_sts,
    output logic signed [OUT_W-1:0] o_quot
);

    localparam int DVD_W = NUM_W + FRAC_SHIFT;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [OUT_W-1:0] r_q;
    logic             r_big;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;

    logic [DEN_W:0]   w_rem_sh;
    logic             w_ge;
    logic [DEN_W:0]   w_rem_sub;

    // one trial subtraction
    always_comb begin
        w_rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub = w_rem_sh - {1'b0, r_den};
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_dvd <= {i_num, {FRAC_SHIFT{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
            r_neg <= i_ctl.neg;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
            r_q   <= {r_q[OUT_W-2:0], w_ge};
            if (r_q[OUT_W-1]) begin
                r_big <= 1'b1;
            end
        end
    end

    // sign and saturation
    always_comb begin
        if (r_neg) begin
            if (r_big || (r_q[OUT_W-1] && (|r_q[OUT_W-2:0]))) begin
                o_quot = OUT_MIN;
            end else begin
                o_quot = -$signed(r_q);
            end
        end else begin
            if (r_big || r_q[OUT_W-1]) begin
                o_quot = OUT_MAX;
            end else begin
                o_quot = $signed(r_q);
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

@@ bench/commodity_channel_index_stream_test.sv @@
// ----------------------------------------------------------------------------
// commodity_channel_index_stream_test
// Self-checking bench: price bars are sent through a valid/stall channel, a
// behavioral predictor computes the expected index per bar, and each output
// transfer is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module commodity_channel_index_stream_test;
    import cci_pkg::*;

    localparam int WIN_MAX = 1024;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PERIOD_W-1:0] i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in                 i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out                o_out_data;

    commodity_channel_index_stream u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // predictor state
    logic [PERIOD_W-1:0] cur_period;
    logic [X_W-1:0]      bar_window [WIN_MAX-1];
    logic [63:0]         bar_sum;
    int                  bars_held;
    int                  next_slot;

    t_out expected_q [$];
    int   fail_count;
    bit   sender_gaps;
    bit   receiver_gaps;
    bit   hold_receiver;
    int   hold_cycles;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // effective window length
    function automatic int window_len(logic [PERIOD_W-1:0] p);
        if (p < 2) return 2;
        if (p > WIN_MAX) return WIN_MAX;
        return int'(p);
    endfunction

    function automatic logic [63:0] abs_gap(logic [63:0] a, logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // expected index for one bar; updates the predictor window
    function automatic t_out predict_index(t_in bar);
        int              n;
        int              slots;
        logic [X_W-1:0]  x;
        logic [63:0]     s;
        logic [63:0]     nx;
        logic [63:0]     dev;
        logic [63:0]     mag;
        logic [127:0]    num;
        logic [127:0]    quo;
        logic [40:0]     q;
        t_out            r;
        n = window_len(cur_period);
        slots = n - 1;
        x = X_W'(bar.high_price) + X_W'(bar.low_price) + X_W'(bar.close_price);
        if (next_slot >= slots) next_slot = 0;
        r = '0;
        if (bars_held < slots) begin
            bar_window[next_slot] = x;
            bar_sum += x;
            bars_held++;
            next_slot = (next_slot + 1 >= slots) ? 0 : next_slot + 1;
            return r;
        end
        s = bar_sum + x;
        nx = 64'(n) * x;
        dev = abs_gap(nx, s);
        for (int i = 0; i < slots; i++) dev += abs_gap(64'(n) * bar_window[i], s);
        mag = abs_gap(nx, s);
        r.ready_res = 1'b1;
        if (mag != 0 && dev != 0) begin
            num = 128'(mag) * 128'(64'(n) * 200 * 65536);
            quo = num / (128'(dev) * 3);
            q = (quo >= (128'd1 << 40)) ? (41'd1 << 40) : quo[40:0];
            if (nx < s) begin
                if (q > 41'(OUT_MAX) + 1) q = 41'(OUT_MAX) + 1;
                r.index_value = -$signed({1'b0, q[39:0]});
            end else begin
                r.index_value = (q > 41'(OUT_MAX)) ? OUT_MAX : q[39:0];
            end
        end
        bar_sum = s - bar_window[next_slot];
        bar_window[next_slot] = x;
        next_slot = (next_slot + 1 >= slots) ? 0 : next_slot + 1;
        return r;
    endfunction

    // send one bar and record its expected index; valid stays high after the
    // transfer so the next bar can follow without a gap
    task automatic send_bar(t_in bar);
        if (sender_gaps && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= bar;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_q.push_back(predict_index(bar));
    endtask

    function automatic t_in rand_bar();
        t_in b;
        b.high_price  = $urandom;
        b.low_price   = $urandom;
        b.close_price = $urandom;
        return b;
    endfunction

    // realistic bar around a price level
    function automatic t_in market_bar(int unsigned level);
        t_in b;
        b.low_price   = level + $urandom_range(0, 4000);
        b.high_price  = b.low_price + $urandom_range(0, 9000);
        b.close_price = b.low_price + $urandom_range(0, 9000);
        return b;
    endfunction

    // stop offering, wait for all results, then let the sequencer settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (WIN_MAX + 200) @(posedge i_clk);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] p);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_period = p;
        bar_sum = 0;
        bars_held = 0;
        next_slot = 0;
    endtask

    // output side: stall bursts, optional long hold, checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b1;
            hold_cycles <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("index transfer with nothing expected");
                    fail_count++;
                end else begin
                    t_out e;
                    e = expected_q.pop_front();
                    if (o_out_data.index_value !== e.index_value) begin
                        $error("index_value expected %0d actual %0d",
                               e.index_value, o_out_data.index_value);
                        fail_count++;
                    end
                    if (o_out_data.ready_res !== e.ready_res) begin
                        $error("ready_res expected %0b actual %0b",
                               e.ready_res, o_out_data.ready_res);
                        fail_count++;
                    end
                end
            end
            if (hold_receiver) begin
                i_out_stall <= 1'b1;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_stall <= 1'b1;
            end else if (receiver_gaps && $urandom_range(5) == 0) begin
                hold_cycles <= $urandom_range(0, 15);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // directed: extremes, warm-up, zero deviation, zero numerator
    task automatic test_directed();
        t_in b;
        write_period(11'd2);
        b = '0;                       send_bar(b);
        send_bar(b);                  // zero deviation
        b = '1;                       send_bar(b); // huge positive
        b = '0;                       send_bar(b); // negative
        b = '1;                       send_bar(b);
        send_bar(b);                  // zero numerator
        b = '0; b.high_price = 32'd1; send_bar(b);
        b = '0;                       send_bar(b);
        b = '1;                       send_bar(b);
        write_period(11'd5);
        for (int i = 0; i < 4; i++) send_bar(market_bar(32'h0064_0000));
        b = '1;                       send_bar(b); // large positive
        b = '0;                       send_bar(b);
        for (int i = 0; i < 5; i++) send_bar(rand_bar());
    endtask

    // out-of-range periods act as the clamped value
    task automatic test_period_clamp();
        write_period(11'd0);
        for (int i = 0; i < 6; i++) send_bar(rand_bar());
        write_period(11'd1);
        for (int i = 0; i < 6; i++) send_bar(market_bar($urandom_range(1, 200) << 16));
        write_period(11'h7FF);
        for (int i = 0; i < 20; i++) send_bar(market_bar(32'h0032_0000));
    endtask

    // a longer window that fills and then wraps
    task automatic test_full_window();
        write_period(11'd64);
        for (int i = 0; i < 70; i++) send_bar(market_bar(32'h00C8_0000 + i * 100));
    endtask

    // random content over several periods
    task automatic test_random();
        int p;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            p = (ph == 0) ? 14 : $urandom_range(2, 40);
            write_period(PERIOD_W'(p));
            for (int i = 0; i < 60; i++) begin
                if ($urandom_range(4) == 0) send_bar(rand_bar());
                else send_bar(market_bar($urandom_range(0, 32'hFFFF_0000 / 3)));
            end
        end
    endtask

    // receiver holds off while bars keep coming
    task automatic test_backpressure();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        write_period(11'd3);
        hold_receiver = 1'b1;
        fork
            for (int i = 0; i < 12; i++) send_bar(market_bar(32'h0010_0000));
            begin
                repeat (3000) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
        join
        for (int i = 0; i < 30; i++) send_bar(rand_bar());
        drain();
    endtask

    initial begin
        fail_count    = 0;
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        hold_receiver = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        cur_period = PERIOD_RST;
        bar_sum = 0;
        bars_held = 0;
        next_slot = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset period first
        for (int i = 0; i < 20; i++) send_bar(market_bar(32'h0020_0000));
        test_directed();
        test_random();
        test_period_clamp();
        test_full_window();
        test_backpressure();
        if (fail_count == 0) begin
            $display("commodity_channel_index_stream_test passed");
        end else begin
            $display("commodity_channel_index_stream_test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #100000000;
        $display("commodity_channel_index_stream_test failed");
        $finish;
    end

endmodule

@@ commodity_channel_index_stream.f @@
src/cci_pkg.sv
src/cci_div.sv
src/commodity_channel_index_stream.sv
bench/commodity_channel_index_stream_test.sv
